FILE: hdl/sms_pkg.sv
// Shared types, codes and helpers for the stepper move sequencer.
`default_nettype none

package sms_pkg;

	// Operation codes carried by an input beat.
	localparam logic [1:0] OP_MOVE    = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY    = 4'd1;

	// Reset values of the configuration registers.
	localparam logic [15:0] STEPS_PER_REV_RST = 16'd200;
	localparam logic [15:0] STEP_DELAY_RST    = 16'd5;

	// Saturation point of the elapsed tick counter.
	localparam logic [15:0] TICKS_MAX = 16'hFFFF;

	// Full-step coil patterns.
	localparam logic [3:0] COIL_PH0 = 4'd5;
	localparam logic [3:0] COIL_PH1 = 4'd6;
	localparam logic [3:0] COIL_PH2 = 4'd10;
	localparam logic [3:0] COIL_PH3 = 4'd9;
	localparam logic [3:0] COIL_OFF = 4'd0;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] step_count;
		logic               limit_min_hit;
		logic               limit_max_hit;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  coils;
		logic [15:0] steps_remaining;
		logic        stepped;
		logic        limit_abort;
		logic        blocked;
		logic [15:0] position;
	} out_item_t;

	// Configuration seen by the step core.
	typedef struct packed {
		logic [15:0] steps_per_rev;
		logic [15:0] step_delay_ticks;
	} cfg_t;

	// Coil pattern for the two low bits of the position.
	function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
		logic [3:0] pat;
		case (phase)
			2'd0:    pat = COIL_PH0;
			2'd1:    pat = COIL_PH1;
			2'd2:    pat = COIL_PH2;
			default: pat = COIL_PH3;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/stepper_move_sequencer.sv
// Top level of the four-wire full-step stepper move sequencer.
// An accepted input beat reaches its result beat through the input register,
// then the state update and the result register.
// Throughput: one item per cycle; the input side stalls only when both the
// input register and the result register are full and the result is stalled.
// Reset: arst_n clears position, direction, pending steps, elapsed ticks, coils
// and the blocked flag, and loads 200 steps per revolution and a 5 tick delay.
`default_nettype none

module stepper_move_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire sms_pkg::in_item_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output sms_pkg::out_item_t                 out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data
);

	sms_pkg::cfg_t      cfg;
	sms_pkg::in_item_t  item_s1;
	logic               valid_s1;
	sms_pkg::out_item_t res;
	sms_pkg::out_item_t out_data_q;
	logic               out_valid_q;
	logic               advance;
	logic               in_take;

	sms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pipeline handshake: the input register empties into the result register.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	sms_step_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (advance),
		.item       (item_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

FILE: hdl/sms_cfg_regs.sv
// Configuration register file of the stepper move sequencer.
`default_nettype none

module sms_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data,
	output sms_pkg::cfg_t                      cfg
);

	logic [15:0] steps_per_rev_q;
	logic [15:0] step_delay_q;

	// Writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_per_rev_q <= sms_pkg::STEPS_PER_REV_RST;
			step_delay_q    <= sms_pkg::STEP_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sms_pkg::CFG_STEPS_PER_REV: steps_per_rev_q <= cfg_data;
				sms_pkg::CFG_STEP_DELAY:    step_delay_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.steps_per_rev    = steps_per_rev_q;
	assign cfg.step_delay_ticks = step_delay_q;

endmodule

`default_nettype wire

FILE: hdl/sms_step_core.sv
// Motor state registers and the single-pass update for one item.
`default_nettype none

module sms_step_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire sms_pkg::in_item_t item,
	input  wire sms_pkg::cfg_t     cfg,
	output sms_pkg::out_item_t     res
);

	logic [15:0] position_q;
	logic        forward_q;
	logic [15:0] pending_q;
	logic [15:0] ticks_q;
	logic [3:0]  coil_q;
	logic        blocked_q;

	logic [15:0] position_d;
	logic        forward_d;
	logic [15:0] pending_d;
	logic [15:0] ticks_d;
	logic [3:0]  coil_d;
	logic        blocked_d;
	logic [15:0] report;
	logic        stepped;
	logic        aborted;

	logic [15:0] rev;
	logic [15:0] ticks_inc;
	logic [15:0] step_pos;
	logic [15:0] mag;
	logic        dir_hit;

	// Zero steps per revolution behaves as one.
	assign rev       = (cfg.steps_per_rev == 16'd0) ? 16'd1 : cfg.steps_per_rev;
	assign ticks_inc = (ticks_q != sms_pkg::TICKS_MAX) ? ticks_q + 16'd1 : ticks_q;
	assign mag       = 16'd0 - item.step_count;
	assign dir_hit   = (item.limit_min_hit && !forward_q) || (item.limit_max_hit && forward_q);

	// Next position for one step in the current direction, wrapping at rev.
	always_comb begin
		if (forward_q) begin
			if ({1'b0, position_q} + 17'd1 >= {1'b0, rev}) begin
				step_pos = 16'd0;
			end else begin
				step_pos = position_q + 16'd1;
			end
		end else begin
			if (position_q == 16'd0 || position_q >= rev) begin
				step_pos = rev - 16'd1;
			end else begin
				step_pos = position_q - 16'd1;
			end
		end
	end

	// Item decode and state update.
	always_comb begin
		position_d = position_q;
		forward_d  = forward_q;
		pending_d  = pending_q;
		ticks_d    = ticks_q;
		coil_d     = coil_q;
		blocked_d  = blocked_q;
		stepped    = 1'b0;
		aborted    = 1'b0;
		report     = pending_q;
		unique case (item.operation)
			sms_pkg::OP_MOVE: begin
				if (item.step_count == 16'sd0) begin
					pending_d = 16'd0;
				end else if (item.step_count[15]) begin
					forward_d = 1'b0;
					pending_d = mag;
				end else begin
					forward_d = 1'b1;
					pending_d = item.step_count;
				end
				report = pending_d;
			end
			sms_pkg::OP_TICK: begin
				ticks_d = ticks_inc;
				if (pending_q != 16'd0) begin
					blocked_d = item.limit_min_hit || item.limit_max_hit;
					if (dir_hit) begin
						aborted   = 1'b1;
						pending_d = 16'd0;
					end else if (ticks_inc >= cfg.step_delay_ticks) begin
						ticks_d    = 16'd0;
						position_d = step_pos;
						coil_d     = sms_pkg::coil_pattern(step_pos[1:0]);
						pending_d  = pending_q - 16'd1;
						stepped    = 1'b1;
						report     = pending_d;
					end
				end
			end
			sms_pkg::OP_RELEASE: begin
				coil_d = sms_pkg::COIL_OFF;
			end
			default: ;
		endcase
	end

	// State registers advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= 16'd0;
			forward_q  <= 1'b0;
			pending_q  <= 16'd0;
			ticks_q    <= 16'd0;
			coil_q     <= sms_pkg::COIL_OFF;
			blocked_q  <= 1'b0;
		end else if (item_valid) begin
			position_q <= position_d;
			forward_q  <= forward_d;
			pending_q  <= pending_d;
			ticks_q    <= ticks_d;
			coil_q     <= coil_d;
			blocked_q  <= blocked_d;
		end
	end

	assign res.coils           = coil_d;
	assign res.steps_remaining = report;
	assign res.stepped         = stepped;
	assign res.limit_abort     = aborted;
	assign res.blocked         = blocked_d;
	assign res.position        = position_d;

	// A step and an abort never happen on the same item.
	a_step_xor_abort: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> !(stepped && aborted))
		else $error("step and limit abort on the same item");

	// After a step the coils carry a full-step pattern.
	a_step_coils: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && stepped |=> (coil_q == sms_pkg::COIL_PH0 || coil_q == sms_pkg::COIL_PH1
			|| coil_q == sms_pkg::COIL_PH2 || coil_q == sms_pkg::COIL_PH3))
		else $error("coil pattern invalid after step");

	// An abort leaves nothing pending.
	a_abort_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && aborted |=> pending_q == 16'd0)
		else $error("pending steps left after abort");

	// A step restarts the elapsed counter.
	a_step_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && stepped |=> ticks_q == 16'd0)
		else $error("elapsed counter not cleared on step");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the stepper move sequencer with random and directed beats.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Code that the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Coil pattern for each position phase, phase 0 in the low nibble.
	localparam logic [15:0] PHASE_COILS = {sms_pkg::COIL_PH3, sms_pkg::COIL_PH2,
		sms_pkg::COIL_PH1, sms_pkg::COIL_PH0};
	localparam int IDLE_PERCENT = 19;
	localparam int CALM_FIRST = 300;
	localparam int CALM_LAST = 450;
	localparam int HOLDOFF_AT = 700;
	localparam int HOLDOFF_CYCLES = 60;
	localparam int SOAK_TICKS = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sms_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sms_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	stepper_move_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Beats waiting to be offered and results the motor model has worked out.
	sms_pkg::in_item_t move_beats[$];
	sms_pkg::out_item_t expected_motion[$];

	int error_count = 0;
	int beats_accepted = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int steps_taken = 0;
	int aborts_seen = 0;

	// Model copy of the configuration and of the motor state.
	logic [15:0] model_rev = sms_pkg::STEPS_PER_REV_RST;
	logic [15:0] model_delay = sms_pkg::STEP_DELAY_RST;
	logic [15:0] model_pos = '0;
	logic        model_fwd = 1'b0;
	logic [15:0] model_pending = '0;
	logic [15:0] model_elapsed = '0;
	logic [3:0]  model_coils = sms_pkg::COIL_OFF;
	logic        model_blocked = 1'b0;

	int holdoff_left = 0;
	logic holdoff_done = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// One step of the motor in the current direction, with wrap at the revolution size.
	task automatic take_step();
		int unsigned rev;
		rev = (model_rev == 16'd0) ? 1 : model_rev;
		if (model_fwd) begin
			if (model_pos + 1 >= rev)
				model_pos = '0;
			else
				model_pos = model_pos + 16'd1;
		end else begin
			if (model_pos == 16'd0 || model_pos >= rev)
				model_pos = 16'(rev - 1);
			else
				model_pos = model_pos - 16'd1;
		end
		model_coils = PHASE_COILS[model_pos[1:0]*4 +: 4];
	endtask

	// Works out the result beat caused by one accepted input beat.
	task automatic predict_motion(input sms_pkg::in_item_t beat, output sms_pkg::out_item_t res);
		logic [15:0] raw;
		logic [15:0] report;
		logic stepped;
		logic aborted;
		raw = beat.step_count;
		report = '0;
		stepped = 1'b0;
		aborted = 1'b0;
		case (beat.operation)
			sms_pkg::OP_MOVE: begin
				if (raw == 16'd0) begin
					model_pending = '0;
				end else if (raw[15]) begin
					model_fwd = 1'b0;
					model_pending = ~raw + 16'd1;
				end else begin
					model_fwd = 1'b1;
					model_pending = raw;
				end
				report = model_pending;
			end
			sms_pkg::OP_TICK: begin
				if (model_elapsed != sms_pkg::TICKS_MAX)
					model_elapsed = model_elapsed + 16'd1;
				if (model_pending != 16'd0) begin
					model_blocked = beat.limit_min_hit | beat.limit_max_hit;
					if ((beat.limit_min_hit && !model_fwd)
							|| (beat.limit_max_hit && model_fwd)) begin
						aborted = 1'b1;
						report = model_pending;
						model_pending = '0;
					end else if (model_elapsed >= model_delay) begin
						model_elapsed = '0;
						take_step();
						model_pending = model_pending - 16'd1;
						stepped = 1'b1;
						report = model_pending;
					end else begin
						report = model_pending;
					end
				end
			end
			sms_pkg::OP_RELEASE: begin
				model_coils = sms_pkg::COIL_OFF;
				report = model_pending;
			end
			default: begin
				report = model_pending;
			end
		endcase
		steps_taken += stepped;
		aborts_seen += aborted;
		res.coils = model_coils;
		res.steps_remaining = report;
		res.stepped = stepped;
		res.limit_abort = aborted;
		res.blocked = model_blocked;
		res.position = model_pos;
	endtask

	function automatic sms_pkg::in_item_t make_beat(input logic [1:0] op,
			input logic signed [15:0] n, input logic lmin, input logic lmax);
		sms_pkg::in_item_t b;
		b.operation = op;
		b.step_count = n;
		b.limit_min_hit = lmin;
		b.limit_max_hit = lmax;
		return b;
	endfunction

	// Mostly ticks behind short moves, so that steps and aborts happen often.
	function automatic sms_pkg::in_item_t random_beat();
		sms_pkg::in_item_t b;
		int r;
		int mag;
		r = $urandom_range(99);
		b.step_count = 16'($urandom);
		b.limit_min_hit = ($urandom_range(99) < 8);
		b.limit_max_hit = ($urandom_range(99) < 8);
		if (r < 68) begin
			b.operation = sms_pkg::OP_TICK;
		end else if (r < 88) begin
			b.operation = sms_pkg::OP_MOVE;
			if ($urandom_range(3) != 0) begin
				mag = $urandom_range(24, 1);
				b.step_count = $urandom_range(1) ? 16'(mag) : 16'(-mag);
			end
		end else if (r < 95) begin
			b.operation = sms_pkg::OP_RELEASE;
		end else if (r < 98) begin
			b.operation = OP_UNUSED;
		end else begin
			b.operation = sms_pkg::OP_MOVE;
			b.step_count = '0;
		end
		return b;
	endfunction

	task automatic queue_random(input int count);
		repeat (count) move_beats.push_back(random_beat());
	endtask

	// Register write on the configuration channel; the model follows on acceptance.
	task automatic write_reg(input logic [sms_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == sms_pkg::CFG_STEPS_PER_REV)
			model_rev = val;
		else if (idx == sms_pkg::CFG_STEP_DELAY)
			model_delay = val;
		reg_writes++;
	endtask

	// Waits until every beat has gone through and the pipeline has settled.
	task automatic drain();
		do @(posedge clk);
		while (move_beats.size() != 0 || in_valid || expected_motion.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Input driver: offers queued beats, holds a stalled beat, idles at random.
	always @(posedge clk or negedge arst_n) begin : drive_moves
		sms_pkg::out_item_t res;
		logic idle;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_motion(in_data, res);
				expected_motion.push_back(res);
				beats_accepted++;
			end
			if (!in_valid || !in_stall) begin
				idle = ($urandom_range(99) < IDLE_PERCENT)
					&& !(beats_accepted >= CALM_FIRST && beats_accepted < CALM_LAST);
				if (move_beats.size() != 0 && !idle) begin
					in_valid <= 1'b1;
					in_data <= move_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result beat and drives the stall, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin : watch_results
		sms_pkg::out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_motion.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result beat, expected none, actual %h",
						$time, out_data);
				end else begin
					want = expected_motion.pop_front();
					check_field("coils", want.coils, out_data.coils);
					check_field("steps_remaining", want.steps_remaining,
						out_data.steps_remaining);
					check_field("stepped", want.stepped, out_data.stepped);
					check_field("limit_abort", want.limit_abort, out_data.limit_abort);
					check_field("blocked", want.blocked, out_data.blocked);
					check_field("position", want.position, out_data.position);
				end
			end
			if (holdoff_left != 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else if (results_seen >= HOLDOFF_AT && !holdoff_done) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PERCENT)
					&& !(results_seen >= CALM_FIRST && results_seen < CALM_LAST);
			end
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Directed checks at the reset settings.
		move_beats.push_back(make_beat(sms_pkg::OP_TICK, 16'sd0, 1'b1, 1'b1));
		move_beats.push_back(make_beat(sms_pkg::OP_MOVE, 16'sd0, 1'b0, 1'b0));
		move_beats.push_back(make_beat(sms_pkg::OP_MOVE, 16'sd3, 1'b1, 1'b1));
		repeat (5) move_beats.push_back(make_beat(sms_pkg::OP_TICK, 16'sh7FFF, 1'b0, 1'b0));
		move_beats.push_back(make_beat(sms_pkg::OP_RELEASE, 16'sd0, 1'b0, 1'b0));
		repeat (5) move_beats.push_back(make_beat(sms_pkg::OP_TICK, -16'sd1, 1'b0, 1'b0));
		move_beats.push_back(make_beat(sms_pkg::OP_MOVE, -16'sd32768, 1'b0, 1'b0));
		move_beats.push_back(make_beat(sms_pkg::OP_TICK, 16'sd0, 1'b1, 1'b0));
		move_beats.push_back(make_beat(sms_pkg::OP_MOVE, 16'sd32767, 1'b0, 1'b0));
		move_beats.push_back(make_beat(sms_pkg::OP_TICK, 16'sd0, 1'b1, 1'b1));
		move_beats.push_back(make_beat(sms_pkg::OP_MOVE, 16'sd5, 1'b0, 1'b0));
		move_beats.push_back(make_beat(sms_pkg::OP_TICK, 16'sd0, 1'b1, 1'b0));
		move_beats.push_back(make_beat(OP_UNUSED, -16'sd1, 1'b1, 1'b1));
		move_beats.push_back(make_beat(sms_pkg::OP_MOVE, -16'sd2, 1'b0, 1'b0));
		repeat (4) move_beats.push_back(make_beat(sms_pkg::OP_TICK, 16'sd0, 1'b0, 1'b1));
		drain();

		// Fast stepping round the default revolution.
		write_reg(sms_pkg::CFG_STEP_DELAY, 16'd0);
		queue_random(250);
		drain();

		// Revolution lowered below the current position.
		write_reg(sms_pkg::CFG_STEPS_PER_REV, 16'd7);
		write_reg(sms_pkg::CFG_STEP_DELAY, 16'd2);
		queue_random(150);
		drain();

		// A zero revolution size behaves as one step.
		write_reg(sms_pkg::CFG_STEPS_PER_REV, 16'd0);
		write_reg(sms_pkg::CFG_STEP_DELAY, 16'd1);
		queue_random(100);
		drain();

		write_reg(sms_pkg::CFG_STEPS_PER_REV, 16'd1);
		write_reg(sms_pkg::CFG_STEP_DELAY, 16'd0);
		queue_random(100);
		drain();

		write_reg(sms_pkg::CFG_STEPS_PER_REV, 16'hFFFF);
		write_reg(sms_pkg::CFG_STEP_DELAY, 16'd3);
		queue_random(200);
		drain();

		// Ticks against the longest delay, which never runs out here.
		write_reg(sms_pkg::CFG_STEPS_PER_REV, 16'd4);
		write_reg(sms_pkg::CFG_STEP_DELAY, 16'hFFFF);
		move_beats.push_back(make_beat(sms_pkg::OP_MOVE, 16'sd0, 1'b0, 1'b0));
		repeat (SOAK_TICKS)
			move_beats.push_back(make_beat(sms_pkg::OP_TICK, 16'sd0, 1'b0, 1'b0));
		move_beats.push_back(make_beat(sms_pkg::OP_MOVE, 16'sd2, 1'b0, 1'b0));
		repeat (3) move_beats.push_back(make_beat(sms_pkg::OP_TICK, 16'sd0, 1'b0, 1'b0));
		drain();

		write_reg(sms_pkg::CFG_STEP_DELAY, 16'd1);
		queue_random(100);
		drain();

		$display("Checked %0d result beats from %0d input beats over %0d register writes.",
			results_seen, beats_accepted, reg_writes);
		$display("Model took %0d steps and saw %0d limit aborts, with a long hold-off.",
			steps_taken, aborts_seen);
		if (error_count == 0 && expected_motion.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#10ms;
		$display("Timeout at %0t", $time);
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/sms_pkg.sv
hdl/sms_cfg_regs.sv
hdl/sms_step_core.sv
hdl/stepper_move_sequencer.sv
tb/tb.sv
